// ===== src/fdep_pkg.sv =====
// Shared types, constants and helpers of the FAT directory entry parser.
`timescale 1ns / 1ps
package fdep_pkg;

  localparam int MAX_LONG_RUN = 15;
  localparam int NAME_CHARS   = 13;
  localparam int NAME_BYTES   = 11;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] ATTR_LONG   = 8'h0F;
  localparam logic [7:0] ATTR_VOLUME = 8'h08;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_DOT    = 8'h2E;

  localparam logic [4:0] OFF_ATTR     = 5'd11;
  localparam logic [4:0] OFF_LNAME_LO = 5'd14;
  localparam logic [4:0] OFF_LNAME_HI = 5'd24;
  localparam logic [4:0] OFF_CLUS_LO  = 5'd26;
  localparam logic [4:0] OFF_CLUS_HI  = 5'd27;
  localparam logic [4:0] OFF_SIZE     = 5'd28;
  localparam logic [4:0] OFF_TAIL_CH  = 5'd30;
  localparam logic [4:0] OFF_LAST     = 5'd31;

  typedef enum logic [1:0] {
    KIND_CHAR   = 2'd0,
    KIND_RECORD = 2'd1,
    KIND_END    = 2'd2
  } fdep_kind_t;

  // How the current 32-byte entry is handled from the attribute byte on.
  typedef enum logic [1:0] {
    ENT_PENDING,
    ENT_LONG,
    ENT_SHORT,
    ENT_SKIP
  } fdep_entry_t;

  typedef enum logic [1:0] {
    TOK_END,
    TOK_LONG,
    TOK_SHORT,
    TOK_REC
  } fdep_op_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       dir_start;
  } fdep_in_t;

  typedef struct packed {
    fdep_kind_t  kind;
    logic [7:0]  char_pos;
    logic [7:0]  char_value;
    logic [7:0]  attributes;
    logic [15:0] first_cluster;
    logic [31:0] file_size;
    logic [7:0]  name_length;
    logic [7:0]  entry_index;
    logic        has_long_name;
    logic        last;
  } fdep_out_t;

  // Work item passed from the front end to the result generator.
  typedef struct packed {
    fdep_op_t                         op;
    logic [3:0]                       count;     // results this token expands to
    logic [3:0]                       stem_len;  // short name: chars before the dot
    logic [7:0]                       base;      // long name: position of chars[0]
    logic [NAME_BYTES-1:0][7:0]       chars;
    logic [7:0]                       attributes;
    logic [15:0]                      first_cluster;
    logic [31:0]                      file_size;
    logic [7:0]                       name_length;
    logic [7:0]                       entry_index;
    logic                             has_long_name;
  } fdep_tok_t;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) r = c + 8'h20;
    return r;
  endfunction

  // Name position of the first character of long entry number run.
  function automatic logic [7:0] long_base(input logic [3:0] run);
    logic [7:0] r;
    r = 8'(NAME_CHARS) * {4'd0, run - 4'd1};
    return r;
  endfunction

endpackage

// ===== src/fdep_front.sv =====
// Front end: takes directory bytes, tracks entry state and issues work tokens.
`timescale 1ns / 1ps
module fdep_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  fdep_pkg::fdep_in_t  in_data,
  output logic              push,
  output fdep_pkg::fdep_tok_t push_tok,
  input  logic              q_full
);
  import fdep_pkg::*;

  logic [4:0]                 off_r, off_c, off_nxt;
  logic [3:0]                 run_r, run_c, run_nxt;
  logic                       pending_r, pending_c, pending_nxt;
  logic [NAME_BYTES-1:0][7:0] names_r, names_nxt;
  logic [7:0]                 attr_r, attr_c, attr_nxt;
  logic [15:0]                clus_r, clus_c, clus_nxt;
  logic [31:0]                size_r, size_c, size_nxt;
  logic [7:0]                 llen_r, llen_c, llen_nxt;
  logic [7:0]                 cnt_r, cnt_c, cnt_nxt;
  logic                       ended_r, ended_c, ended_nxt;
  fdep_entry_t                ent_r, ent_c, ent_nxt;

  logic                       accept;
  logic [7:0]                 b;
  logic [3:0]                 ord, ord_sat;
  logic [3:0]                 stem_len, name_len;
  logic [1:0]                 ext_len;
  logic [7:0]                 sn_zero;
  logic                       lz_hit;
  logic [2:0]                 lz_k;
  logic [7:0]                 base11, lpos;
  logic [3:0]                 lk;
  logic                       lchar_off;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign b        = in_data.data_byte;
  assign ord      = names_r[0][3:0];
  assign ord_sat  = (ord > 4'(MAX_LONG_RUN)) ? 4'(MAX_LONG_RUN) : ord;

  // Short 8.3 name layout: stem length, trimmed extension and first zero.
  always_comb begin
    logic stop;
    logic found;
    stop     = 1'b0;
    found    = 1'b0;
    stem_len = 4'd1;
    for (int i = 1; i < 8; i++) begin
      if (!stop) begin
        if (names_r[i] == CHAR_SPACE) stop = 1'b1;
        else stem_len = 4'(i + 1);
      end
    end
    if (names_r[10] != CHAR_SPACE)     ext_len = 2'd3;
    else if (names_r[9] != CHAR_SPACE) ext_len = 2'd2;
    else if (names_r[8] != CHAR_SPACE) ext_len = 2'd1;
    else                               ext_len = 2'd0;
    name_len = stem_len + ((ext_len != 2'd0) ? ({2'd0, ext_len} + 4'd1) : 4'd0);
    sn_zero  = {4'd0, name_len};
    for (int j = 0; j < 8; j++) begin
      if (!found && (4'(j) < stem_len) && (names_r[j] == 8'd0)) begin
        found   = 1'b1;
        sn_zero = 8'(j);
      end
    end
    for (int j = 0; j < 3; j++) begin
      if (!found && (2'(j) < ext_len) && (names_r[8 + j] == 8'd0)) begin
        found   = 1'b1;
        sn_zero = 8'(int'(stem_len) + 1 + j);
      end
    end
  end

  // First zero among the five long-name chars held in bytes 1..9.
  always_comb begin
    lz_hit = 1'b0;
    lz_k   = 3'd0;
    for (int k = 4; k >= 0; k--) begin
      if (names_r[1 + 2 * k] == 8'd0) begin
        lz_hit = 1'b1;
        lz_k   = 3'(k);
      end
    end
  end

  always_comb begin
    // dir_start clears the parse state before this byte is taken
    off_c     = in_data.dir_start ? 5'd0 : off_r;
    run_c     = in_data.dir_start ? 4'd0 : run_r;
    pending_c = in_data.dir_start ? 1'b0 : pending_r;
    attr_c    = in_data.dir_start ? 8'd0 : attr_r;
    clus_c    = in_data.dir_start ? 16'd0 : clus_r;
    size_c    = in_data.dir_start ? 32'd0 : size_r;
    llen_c    = in_data.dir_start ? 8'd0 : llen_r;
    cnt_c     = in_data.dir_start ? 8'd0 : cnt_r;
    ended_c   = in_data.dir_start ? 1'b0 : ended_r;
    ent_c     = in_data.dir_start ? ENT_PENDING : ent_r;

    off_nxt     = off_c;
    run_nxt     = run_c;
    pending_nxt = pending_c;
    names_nxt   = names_r;
    attr_nxt    = attr_c;
    clus_nxt    = clus_c;
    size_nxt    = size_c;
    llen_nxt    = llen_c;
    cnt_nxt     = cnt_c;
    ended_nxt   = ended_c;
    ent_nxt     = ent_c;

    push     = 1'b0;
    push_tok = '0;
    base11   = 8'd0;

    lchar_off = ((off_c >= OFF_LNAME_LO) && (off_c <= OFF_LNAME_HI) && !off_c[0]) ||
                (off_c == OFF_SIZE) || (off_c == OFF_TAIL_CH);
    lk   = (off_c >= OFF_SIZE) ? (off_c[4:1] - 4'd3) : (off_c[4:1] - 4'd2);
    lpos = long_base(run_c) + {4'd0, lk};

    if (!ended_c) begin
      if (off_c == 5'd0 && run_c == 4'd0 && b == 8'd0) begin
        ended_nxt            = 1'b1;
        push                 = accept;
        push_tok.op          = TOK_END;
        push_tok.count       = 4'd1;
        push_tok.entry_index = cnt_c;
      end else begin
        off_nxt = off_c + 5'd1;
        if (off_c < OFF_ATTR) begin
          names_nxt[off_c[3:0]] = b;
          if (off_c == 5'd0) ent_nxt = ENT_PENDING;
        end else if (off_c == OFF_ATTR) begin
          attr_nxt = b;
          if (run_c != 4'd0) begin
            ent_nxt = ENT_LONG;
          end else if (b == ATTR_LONG) begin
            if (ord == 4'd0) begin
              ent_nxt = ENT_SKIP;
            end else begin
              run_nxt  = ord_sat;
              llen_nxt = 8'(NAME_CHARS) * {4'd0, ord_sat};
              ent_nxt  = ENT_LONG;
            end
          end else if (b == ATTR_VOLUME) begin
            ent_nxt = ENT_SKIP;
          end else begin
            ent_nxt = ENT_SHORT;
            if (!pending_c) begin
              push              = accept;
              push_tok.op       = TOK_SHORT;
              push_tok.count    = name_len;
              push_tok.stem_len = stem_len;
              push_tok.chars    = names_r;
              llen_nxt          = sn_zero;
            end
          end
          if (ent_nxt == ENT_LONG) begin
            base11         = long_base(run_nxt);
            push           = accept;
            push_tok.op    = TOK_LONG;
            push_tok.count = 4'd5;
            push_tok.base  = base11;
            for (int k = 0; k < 5; k++) push_tok.chars[k] = names_r[1 + 2 * k];
            if (lz_hit && ((base11 + {5'd0, lz_k}) < llen_nxt))
              llen_nxt = base11 + {5'd0, lz_k};
          end
        end else begin
          if (off_c == OFF_CLUS_LO) clus_nxt[7:0] = b;
          else if (off_c == OFF_CLUS_HI) clus_nxt[15:8] = b;
          else if (off_c >= OFF_SIZE) size_nxt[{off_c[1:0], 3'b000} +: 8] = b;

          if (ent_c == ENT_LONG) begin
            if (lchar_off) begin
              push              = accept;
              push_tok.op       = TOK_LONG;
              push_tok.count    = 4'd1;
              push_tok.base     = lpos;
              push_tok.chars[0] = b;
              if (b == 8'd0 && lpos < llen_c) llen_nxt = lpos;
            end
            if (off_c == OFF_LAST) begin
              run_nxt = run_c - 4'd1;
              if (run_c == 4'd1) pending_nxt = 1'b1;
            end
          end else if (ent_c == ENT_SHORT && off_c == OFF_LAST) begin
            push                   = accept;
            push_tok.op            = TOK_REC;
            push_tok.count         = 4'd1;
            push_tok.attributes    = attr_c;
            push_tok.first_cluster = clus_c;
            push_tok.file_size     = size_nxt;
            push_tok.name_length   = llen_c;
            push_tok.entry_index   = cnt_c;
            push_tok.has_long_name = pending_c;
            cnt_nxt                = cnt_c + 8'd1;
            pending_nxt            = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r     <= 5'd0;
      run_r     <= 4'd0;
      pending_r <= 1'b0;
      attr_r    <= 8'd0;
      clus_r    <= 16'd0;
      size_r    <= 32'd0;
      llen_r    <= 8'd0;
      cnt_r     <= 8'd0;
      ended_r   <= 1'b0;
      ent_r     <= ENT_PENDING;
    end else if (accept) begin
      off_r     <= off_nxt;
      run_r     <= run_nxt;
      pending_r <= pending_nxt;
      attr_r    <= attr_nxt;
      clus_r    <= clus_nxt;
      size_r    <= size_nxt;
      llen_r    <= llen_nxt;
      cnt_r     <= cnt_nxt;
      ended_r   <= ended_nxt;
      ent_r     <= ent_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) names_r <= names_nxt;
  end

`ifndef SYNTHESIS
  a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
    run_r <= 4'(MAX_LONG_RUN))
    else $error("long run count above limit");
`endif

endmodule

// ===== src/fdep_queue.sv =====
// Short token queue between the front end and the result generator.
`timescale 1ns / 1ps
module fdep_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  fdep_pkg::fdep_tok_t push_tok,
  output logic                full,
  output logic                head_valid,
  output fdep_pkg::fdep_tok_t head_tok,
  input  logic                pop
);
  import fdep_pkg::*;

  fdep_tok_t           slots_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_r, wr_nxt, rd_r, rd_nxt;
  logic [QPTR_W:0]     cnt_r, cnt_nxt;

  assign full       = (cnt_r == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_tok   = slots_r[rd_r];

  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots_r[wr_r] <= push_tok;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("token written into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("token taken from an empty queue");
`endif

endmodule

// ===== src/fdep_back.sv =====
// Result generator: expands queued tokens into result items, one per cycle while out_stall is low.
`timescale 1ns / 1ps
module fdep_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                head_valid,
  input  fdep_pkg::fdep_tok_t head_tok,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output fdep_pkg::fdep_out_t out_data
);
  import fdep_pkg::*;

  logic [3:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  fdep_out_t  out_r;
  fdep_out_t  res;
  logic       load;
  logic [3:0] ext_i;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign load      = head_valid && (!out_valid_r || !out_stall);
  assign ext_i     = idx_r - head_tok.stem_len - 4'd1;

  always_comb begin
    res      = '0;
    res.last = (idx_r == head_tok.count - 4'd1);
    unique case (head_tok.op)
      TOK_END: begin
        res.kind        = KIND_END;
        res.entry_index = head_tok.entry_index;
      end
      TOK_REC: begin
        res.kind          = KIND_RECORD;
        res.attributes    = head_tok.attributes;
        res.first_cluster = head_tok.first_cluster;
        res.file_size     = head_tok.file_size;
        res.name_length   = head_tok.name_length;
        res.entry_index   = head_tok.entry_index;
        res.has_long_name = head_tok.has_long_name;
      end
      TOK_LONG: begin
        res.kind       = KIND_CHAR;
        res.char_pos   = head_tok.base + {4'd0, idx_r};
        res.char_value = head_tok.chars[idx_r];
      end
      TOK_SHORT: begin
        res.kind     = KIND_CHAR;
        res.char_pos = {4'd0, idx_r};
        if (idx_r < head_tok.stem_len)
          res.char_value = to_lower(head_tok.chars[idx_r]);
        else if (idx_r == head_tok.stem_len)
          res.char_value = CHAR_DOT;
        else
          res.char_value = to_lower(head_tok.chars[4'd8 + {2'd0, ext_i[1:0]}]);
      end
      default: res = '0;
    endcase

    pop           = load && res.last;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (load) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = res.last ? 4'd0 : idx_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_r <= res;
  end

`ifndef SYNTHESIS
  a_token_held: assert property (@(posedge clk) disable iff (!rst_n)
    (idx_r != 4'd0) |-> head_valid)
    else $error("token left the queue before all its results were sent");
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.kind == KIND_END) |-> out_r.last)
    else $error("end of directory result not marked last");
  a_idx_in_token: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> (idx_r < head_tok.count))
    else $error("result index beyond token length");
`endif

endmodule

// ===== src/fat_directory_entry_parser.sv =====
// Top level of the FAT directory entry parser.
`timescale 1ns / 1ps
// Usage:
//   in_*  : one directory byte per transfer; dir_start marks the first byte of a
//           new listing and clears all parse state before that byte is used.
//   out_* : result items (name character, entry record, end of directory); last
//           flags the final result caused by one input byte.
// Path: the results of a byte pass through the token queue and then the output register.
// Throughput: one byte per cycle while the token queue (4 entries) has room and
//   results drain one per cycle. The result generator sets the figure: a short
//   name at the attribute byte expands to up to 12 results, the attribute byte
//   of a long entry to 5. Bytes that produce nothing take no queue slot.
// Reset: synchronous, active low; parse state and queue are emptied and the
//   block starts at offset 0 of a fresh listing.
// Stall: a stalled output register holds its item; tokens pile up in the queue
//   and in_stall rises only when the queue is full.
module fat_directory_entry_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  fdep_pkg::fdep_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output fdep_pkg::fdep_out_t out_data
);
  import fdep_pkg::*;

  logic      push, q_full, head_valid, pop;
  fdep_tok_t push_tok, head_tok;

  fdep_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .push     (push),
    .push_tok (push_tok),
    .q_full   (q_full)
  );

  fdep_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_tok   (push_tok),
    .full       (q_full),
    .head_valid (head_valid),
    .head_tok   (head_tok),
    .pop        (pop)
  );

  fdep_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_tok   (head_tok),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the FAT directory entry parser.
`timescale 1ns / 1ps
module testbench;
  import fdep_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 40;
  localparam int REPORT_MAX     = 100;

  typedef logic [31:0][7:0] entry_bytes_t;
  typedef logic [10:0][7:0] short_name_t;
  typedef logic [12:0][7:0] long_chars_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  fdep_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  fdep_out_t out_data;

  fat_directory_entry_parser uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // Parser state as predicted from the accepted bytes
  logic [4:0]  dir_offset;
  logic [3:0]  run_left;
  logic        long_pending;
  logic [7:0]  name_field [NAME_BYTES];
  logic [7:0]  attr_byte;
  logic [15:0] cluster_word;
  logic [31:0] size_word;
  logic [7:0]  name_length;
  logic [7:0]  record_count;
  logic        listing_ended;
  fdep_entry_t entry_mode;

  fdep_out_t   step_results [$];
  fdep_out_t   expected_results [$];

  int unsigned error_count = 0;
  int          burst_left = 0;
  bit          steady_send = 1'b0;
  bit          restart_next = 1'b1;
  bit          hold_off_req = 1'b0;

  // ---------------------------------------------------------------- predictor

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
  endfunction

  function automatic fdep_out_t char_item(input logic [7:0] pos, input logic [7:0] val);
    fdep_out_t r;
    r = '0;
    r.kind = KIND_CHAR;
    r.char_pos = pos;
    r.char_value = val;
    return r;
  endfunction

  task automatic clear_parse_state();
    dir_offset = '0;
    run_left = '0;
    long_pending = 1'b0;
    foreach (name_field[i]) name_field[i] = '0;
    attr_byte = '0;
    cluster_word = '0;
    size_word = '0;
    name_length = '0;
    record_count = '0;
    listing_ended = 1'b0;
    entry_mode = ENT_PENDING;
  endtask

  task automatic add_long_char(input int k, input logic [7:0] v);
    int pos;
    pos = NAME_CHARS * (int'(run_left) - 1) + k;
    if (v == 8'h00 && pos < int'(name_length)) name_length = 8'(pos);
    step_results.push_back(char_item(8'(pos), v));
  endtask

  task automatic add_short_name();
    logic [7:0] txt [$];
    int ext;
    int nl;
    txt.push_back(fold_case(name_field[0]));
    for (int i = 1; i < 8; i++) begin
      if (name_field[i] == CHAR_SPACE) break;
      txt.push_back(fold_case(name_field[i]));
    end
    // trim trailing spaces of the extension, drop the dot when it is blank
    ext = 3;
    while (ext > 0 && name_field[7 + ext] == CHAR_SPACE) ext--;
    if (ext > 0) begin
      txt.push_back(CHAR_DOT);
      for (int i = 0; i < ext; i++) txt.push_back(fold_case(name_field[8 + i]));
    end
    nl = txt.size();
    for (int i = 0; i < txt.size(); i++) begin
      if (txt[i] == 8'h00) begin
        nl = i;
        break;
      end
    end
    name_length = 8'(nl);
    for (int i = 0; i < txt.size(); i++) step_results.push_back(char_item(8'(i), txt[i]));
  endtask

  task automatic predict_parse(input logic [7:0] b, input logic s);
    fdep_out_t rec;
    int off;
    int cnt;
    step_results.delete();
    if (s) clear_parse_state();
    off = dir_offset;
    if (listing_ended) begin
      // drop everything until the next listing starts
    end else if (off == 0 && run_left == 0 && b == 8'h00) begin
      listing_ended = 1'b1;
      rec = '0;
      rec.kind = KIND_END;
      rec.entry_index = record_count;
      step_results.push_back(rec);
    end else begin
      if (off < OFF_ATTR) begin
        name_field[off] = b;
        if (off == 0) entry_mode = ENT_PENDING;
      end else if (off == OFF_ATTR) begin
        attr_byte = b;
        if (run_left > 0) begin
          entry_mode = ENT_LONG;
        end else if (b == ATTR_LONG) begin
          cnt = int'(name_field[0][3:0]);
          if (cnt == 0) begin
            entry_mode = ENT_SKIP;
          end else begin
            if (cnt > MAX_LONG_RUN) cnt = MAX_LONG_RUN;
            run_left = 4'(cnt);
            name_length = 8'(NAME_CHARS * cnt);
            entry_mode = ENT_LONG;
          end
        end else if (b == ATTR_VOLUME) begin
          entry_mode = ENT_SKIP;
        end else begin
          entry_mode = ENT_SHORT;
          if (!long_pending) add_short_name();
        end
        if (entry_mode == ENT_LONG) begin
          for (int k = 0; k < 5; k++) add_long_char(k, name_field[1 + 2 * k]);
        end
      end else begin
        if (off == OFF_CLUS_LO) cluster_word[7:0] = b;
        else if (off == OFF_CLUS_HI) cluster_word[15:8] = b;
        else if (off >= OFF_SIZE) size_word[8 * (off - OFF_SIZE) +: 8] = b;

        if (entry_mode == ENT_LONG) begin
          if (off >= OFF_LNAME_LO && off <= OFF_LNAME_HI && off % 2 == 0)
            add_long_char(5 + (off - OFF_LNAME_LO) / 2, b);
          else if (off == OFF_SIZE || off == OFF_TAIL_CH)
            add_long_char(11 + (off - OFF_SIZE) / 2, b);
          if (off == OFF_LAST) begin
            run_left = run_left - 4'd1;
            if (run_left == 0) long_pending = 1'b1;
          end
        end else if (entry_mode == ENT_SHORT && off == OFF_LAST) begin
          rec = '0;
          rec.kind = KIND_RECORD;
          rec.attributes = attr_byte;
          rec.first_cluster = cluster_word;
          rec.file_size = size_word;
          rec.name_length = name_length;
          rec.entry_index = record_count;
          rec.has_long_name = long_pending;
          step_results.push_back(rec);
          record_count = record_count + 8'd1;
          long_pending = 1'b0;
        end
      end
      dir_offset = dir_offset + 5'd1;
    end
    if (step_results.size() > 0) begin
      rec = step_results.pop_back();
      rec.last = 1'b1;
      step_results.push_back(rec);
    end
    foreach (step_results[i]) expected_results.push_back(step_results[i]);
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report(input string field, input longint unsigned want,
                        input longint unsigned got);
    error_count++;
    if (error_count <= REPORT_MAX)
      $error("%s: expected %0h, actual %0h", field, want, got);
  endtask

  task automatic check_result(input fdep_out_t got);
    fdep_out_t want;
    if (expected_results.size() == 0) begin
      error_count++;
      if (error_count <= REPORT_MAX)
        $error("unexpected result: kind %0d pos %0d", got.kind, got.char_pos);
    end else begin
      want = expected_results.pop_front();
      if (got.kind !== want.kind) report("kind", want.kind, got.kind);
      if (got.char_pos !== want.char_pos) report("char_pos", want.char_pos, got.char_pos);
      if (got.char_value !== want.char_value)
        report("char_value", want.char_value, got.char_value);
      if (got.attributes !== want.attributes)
        report("attributes", want.attributes, got.attributes);
      if (got.first_cluster !== want.first_cluster)
        report("first_cluster", want.first_cluster, got.first_cluster);
      if (got.file_size !== want.file_size)
        report("file_size", want.file_size, got.file_size);
      if (got.name_length !== want.name_length)
        report("name_length", want.name_length, got.name_length);
      if (got.entry_index !== want.entry_index)
        report("entry_index", want.entry_index, got.entry_index);
      if (got.has_long_name !== want.has_long_name)
        report("has_long_name", want.has_long_name, got.has_long_name);
      if (got.last !== want.last) report("last", want.last, got.last);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) check_result(out_data);
  end

  // Receiver: stall patterns that change now and then, plus a long hold on request
  initial begin : receiver
    stall_mode_t mode;
    int mode_left;
    int period;
    int phase;
    mode = STALL_NONE;
    mode_left = 0;
    period = 2;
    phase = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req <= 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = stall_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 200);
          period = $urandom_range(2, 5);
        end
        mode_left--;
        phase++;
        case (mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:     out_stall <= (phase % period == 0);
        endcase
      end
    end
  end

  // End the run when no transfer happens on either side for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------- stimulus

  task automatic send_byte(input logic [7:0] b, input logic s);
    int gap;
    if (burst_left == 0 && !steady_send) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    in_data <= fdep_in_t'{data_byte: b, dir_start: s};
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    predict_parse(b, s);
  endtask

  task automatic send_entry(input entry_bytes_t e, input logic start);
    logic first;
    first = start | restart_next;
    restart_next = 1'b0;
    for (int i = 0; i < 32; i++) send_byte(e[i], first && i == 0);
  endtask

  function automatic entry_bytes_t random_bytes();
    entry_bytes_t e;
    for (int i = 0; i < 32; i++) e[i] = 8'($urandom);
    return e;
  endfunction

  function automatic logic [7:0] name_char();
    logic [7:0] edges [6] = '{8'h40, 8'h41, 8'h5A, 8'h5B, 8'h60, 8'h7B};
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 8'h41 + 8'($urandom_range(0, 25));
      4:          return 8'h61 + 8'($urandom_range(0, 25));
      5:          return 8'h30 + 8'($urandom_range(0, 9));
      6:          return CHAR_SPACE;
      7:          return 8'h00;
      8:          return edges[$urandom_range(0, 5)];
      default:    return 8'($urandom);
    endcase
  endfunction

  function automatic short_name_t text_name(input string s);
    short_name_t nm;
    for (int i = 0; i < NAME_BYTES; i++) nm[i] = (i < s.len()) ? s[i] : CHAR_SPACE;
    return nm;
  endfunction

  function automatic short_name_t random_short_name();
    short_name_t nm;
    int stem;
    int ext;
    stem = $urandom_range(1, 8);
    ext = $urandom_range(0, 3);
    for (int i = 0; i < NAME_BYTES; i++) nm[i] = name_char();
    // pad most names the way a formatter would
    if ($urandom_range(0, 3) != 0) begin
      for (int i = stem; i < 8; i++) nm[i] = CHAR_SPACE;
      for (int i = 8 + ext; i < NAME_BYTES; i++) nm[i] = CHAR_SPACE;
    end
    return nm;
  endfunction

  function automatic logic [7:0] random_attr();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'h20;
      2:       return 8'h10;
      3:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic entry_bytes_t short_entry(input short_name_t nm, input logic [7:0] attr,
                                               input logic [15:0] clus,
                                               input logic [31:0] size);
    entry_bytes_t e;
    e = random_bytes();
    e[10:0] = nm;
    e[11] = attr;
    e[27:26] = clus;
    e[31:28] = size;
    return e;
  endfunction

  function automatic entry_bytes_t long_entry(input logic [7:0] ord, input long_chars_t ch);
    entry_bytes_t e;
    e = random_bytes();
    e[0] = ord;
    e[11] = ATTR_LONG;
    for (int k = 0; k < 5; k++) e[1 + 2 * k] = ch[k];
    for (int k = 5; k < 11; k++) e[14 + 2 * (k - 5)] = ch[k];
    e[28] = ch[11];
    e[30] = ch[12];
    return e;
  endfunction

  task automatic send_short(input short_name_t nm, input logic [7:0] attr,
                            input logic [15:0] clus, input logic [31:0] size);
    send_entry(short_entry(nm, attr, clus, size), 1'b0);
  endtask

  task automatic send_random_short();
    send_short(random_short_name(), random_attr(), 16'($urandom), $urandom);
  endtask

  // Long-name run of n entries; the name is terminated by a zero at position term
  task automatic send_long_run(input int n, input logic [3:0] top, input int term,
                               input bit odd_inner);
    long_chars_t ch;
    entry_bytes_t e;
    int p;
    for (int i = n; i >= 1; i--) begin
      for (int k = 0; k < NAME_CHARS; k++) begin
        p = NAME_CHARS * (i - 1) + k;
        ch[k] = (p == term) ? 8'h00 : (p > term) ? 8'hFF : name_char();
      end
      e = long_entry({top, 4'(i)}, ch);
      // inner entries are never checked, so let them look odd
      if (i != n && odd_inner) begin
        e[0] = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom);
        e[11] = 8'($urandom);
      end
      send_entry(e, 1'b0);
    end
  endtask

  // A zero first byte at an entry boundary, then bytes that must give nothing
  task automatic send_end_marker(input int trailing);
    send_byte(8'h00, restart_next);
    restart_next = 1'b0;
    for (int i = 0; i < trailing; i++) send_byte(8'($urandom), 1'b0);
    restart_next = 1'b1;
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_short_names();
    short_name_t nm;
    // case edges around the letters, extension with trailing spaces
    nm = text_name("@AZ[_AZ{X  ");
    nm[4] = 8'h60;
    send_short(nm, 8'h20, 16'h8001, 32'h8000_0001);
  endtask

  task automatic test_long_names();
    send_long_run(1, 4'h4, 5, 1'b0);
    send_random_short();
  endtask

  task automatic test_back_pressure();
    hold_off_req <= 1'b1;
    steady_send = 1'b1;
    send_long_run(1, 4'h4, 99, 1'b0);
    send_random_short();
    steady_send = 1'b0;
  endtask

  task automatic test_end_of_directory();
    send_end_marker(3);
  endtask

  initial begin
    clear_parse_state();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_short_names();
    test_long_names();
    test_back_pressure();
    test_end_of_directory();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== sim.f =====
src/fdep_pkg.sv
src/fdep_front.sv
src/fdep_queue.sv
src/fdep_back.sv
src/fat_directory_entry_parser.sv
sim/testbench.sv
